@@ src/ktt_pkg.sv @@
// ============================================================================
// ktt_pkg
// shared widths, codes and types for the keyed trust table
// ============================================================================
`default_nettype none

package ktt_pkg;

   localparam int ADDR_W     = 48;
   localparam int NAME_W     = 64;
   localparam int NAME_WORDS = 4;
   localparam int KEY_W      = ADDR_W + NAME_W * NAME_WORDS;
   localparam int LEVEL_W    = 2;
   localparam int TIME_W     = 32;
   localparam int OP_W       = 2;
   localparam int SLOT_W     = 3;
   localparam int IDX_MAX_W  = 6;
   localparam int ROW_W      = KEY_W + LEVEL_W + TIME_W;

   localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
   localparam logic [OP_W-1:0] OP_STORE   = 2'd1;
   localparam logic [OP_W-1:0] OP_CONNECT = 2'd2;
   localparam logic [OP_W-1:0] OP_CONSUME = 2'd3;

   localparam logic [LEVEL_W-1:0] LEVEL_UNKNOWN = 2'd0;

   // one table row as held in the entry ram
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  last_use;
   } row_type;

   // sequencer to compare unit
   typedef struct packed {
      logic                 clear;
      logic                 vld;
      logic                 in_use;
      logic [IDX_MAX_W-1:0] idx;
   } scan_ctl_type;

   // compare unit to sequencer
   typedef struct packed {
      logic                 found;
      logic [IDX_MAX_W-1:0] match_idx;
      logic [LEVEL_W-1:0]   level;
      logic [IDX_MAX_W-1:0] victim_idx;
   } scan_res_type;

endpackage

`default_nettype wire

@@ src/ktt_ram.sv @@
// ============================================================================
// ktt_ram
// generic single write port ram with one registered read port
// ============================================================================
`default_nettype none

module ktt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/ktt_scan.sv @@
// ============================================================================
// ktt_scan
// shared key compare and oldest-time tracker, one row per cycle
// ============================================================================
`default_nettype none

module ktt_scan
   import ktt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire scan_ctl_type ctl,
   input  wire logic [KEY_W-1:0] key,
   input  wire row_type      row,
   output scan_res_type      res
);

   logic                 found_ff,     found_in;
   logic [IDX_MAX_W-1:0] match_idx_ff, match_idx_in;
   logic [LEVEL_W-1:0]   level_ff,     level_in;
   logic [IDX_MAX_W-1:0] victim_ff,    victim_in;
   logic [TIME_W-1:0]    min_time_ff,  min_time_in;
   logic                 is_match;
   logic                 is_older;

   assign is_match = ctl.in_use && !found_ff && (row.key == key);
   assign is_older = (ctl.idx == '0) || (row.last_use < min_time_ff);

   always_comb begin
      found_in     = found_ff;
      match_idx_in = match_idx_ff;
      level_in     = level_ff;
      victim_in    = victim_ff;
      min_time_in  = min_time_ff;
      if (ctl.clear) begin
         found_in     = 1'b0;
         match_idx_in = '0;
         level_in     = LEVEL_UNKNOWN;
      end else if (ctl.vld) begin
         if (is_match) begin
            found_in     = 1'b1;
            match_idx_in = ctl.idx;
            level_in     = row.level;
         end
         // strict less keeps the lowest index on ties
         if (is_older) begin
            min_time_in = row.last_use;
            victim_in   = ctl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      match_idx_ff <= match_idx_in;
      level_ff     <= level_in;
      victim_ff    <= victim_in;
      min_time_ff  <= min_time_in;
   end

   assign res.found      = found_ff;
   assign res.match_idx  = match_idx_ff;
   assign res.level      = level_ff;
   assign res.victim_idx = victim_ff;

endmodule

`default_nettype wire

@@ src/keyed_trust_table_lru_unit.sv @@
// ============================================================================
// keyed_trust_table_lru_unit
// associative trust table with least-recently-used replacement
// ============================================================================
// Each request walks all ENTRIES rows of a single entry ram, one row per
// cycle, through one shared key compare and oldest-time tracker. After
// acceptance the sequencer passes through a scan state that issues the
// ENTRIES row reads, a drain state for the last registered ram read, and a
// finish state that waits for the response register to be free, then writes
// back and loads it. The drain state is there because the ram read port is
// registered. req_ready is high only while the sequencer is idle; the response
// register lets a new request enter while an earlier response still waits.
// Only rows below the fill count take part in matching, so the ram needs no
// clearing pass after reset.
`default_nettype none

module keyed_trust_table_lru_unit
   import ktt_pkg::*;
#(
   parameter int ENTRIES = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [OP_W-1:0]      req_operation,
   input  wire logic [ADDR_W-1:0]    req_station_addr,
   input  wire logic [NAME_W-1:0]    req_name_word0,
   input  wire logic [NAME_W-1:0]    req_name_word1,
   input  wire logic [NAME_W-1:0]    req_name_word2,
   input  wire logic [NAME_W-1:0]    req_name_word3,
   input  wire logic [LEVEL_W-1:0]   req_new_level,
   input  wire logic [TIME_W-1:0]    req_now_ms,
   input  wire logic [LEVEL_W-1:0]   req_required_level,
   input  wire logic                 req_ap_mode,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [LEVEL_W-1:0]   rsp_found_level,
   output logic                      rsp_hit,
   output logic                      rsp_allowed,
   output logic                      rsp_prompt_pending,
   output logic      [SLOT_W-1:0]    rsp_slot,
   output logic                      rsp_evicted
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]         state_ff,    state_in;
   logic [IDX_W-1:0]   rd_addr_ff,  rd_addr_in;
   logic               chk_vld_ff,  chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff,  chk_idx_in;
   logic [CNT_W-1:0]   count_ff,    count_in;
   logic               prompt_ff,   prompt_in;

   // captured request
   logic [OP_W-1:0]    op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [LEVEL_W-1:0] new_level_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [LEVEL_W-1:0] required_ff;
   logic               ap_ff;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_hit_ff,   rsp_hit_in;
   logic               rsp_allow_ff, rsp_allow_in;
   logic               rsp_prompt_ff, rsp_prompt_in;
   logic [SLOT_W-1:0]  rsp_slot_ff,  rsp_slot_in;
   logic               rsp_evict_ff, rsp_evict_in;

   logic               accept;
   logic               out_free;
   scan_ctl_type       scan_ctl;
   scan_res_type       scan_res;
   logic [ROW_W-1:0]   rd_data;
   row_type            rd_row;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   row_type            wr_row;
   logic [IDX_W-1:0]   target;
   logic [IDX_MAX_W-1:0] slot_wide;
   logic               table_full;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign table_full = (count_ff == CNT_W'(ENTRIES));
   assign rd_row     = row_type'(rd_data);

   // store target: matching row, else next free row, else oldest row
   always_comb begin
      if (scan_res.found) begin
         target = scan_res.match_idx[IDX_W-1:0];
      end else if (!table_full) begin
         target = count_ff[IDX_W-1:0];
      end else begin
         target = scan_res.victim_idx[IDX_W-1:0];
      end
   end

   // compare unit control, one row behind the ram read
   always_comb begin
      scan_ctl.clear  = accept;
      scan_ctl.vld    = chk_vld_ff;
      scan_ctl.in_use = (CNT_W'(chk_idx_ff) < count_ff);
      scan_ctl.idx    = IDX_MAX_W'(chk_idx_ff);
   end

   always_comb begin
      state_in      = state_ff;
      rd_addr_in    = rd_addr_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      count_in      = count_ff;
      prompt_in     = prompt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_level_in  = rsp_level_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_allow_in  = rsp_allow_ff;
      rsp_prompt_in = rsp_prompt_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_evict_in  = rsp_evict_ff;
      wr_en         = 1'b0;
      wr_addr       = target;
      wr_row.key      = key_ff;
      wr_row.level    = new_level_ff;
      wr_row.last_use = now_ff;
      slot_wide     = scan_res.match_idx;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rd_addr_in = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            chk_vld_in = 1'b1;
            chk_idx_in = rd_addr_ff;
            if (rd_addr_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = S_DRAIN;
            end else begin
               rd_addr_in = rd_addr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // last row is compared at the end of this cycle
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_evict_in = 1'b0;
               case (op_ff)
                  OP_STORE: begin
                     wr_en     = 1'b1;
                     slot_wide = IDX_MAX_W'(target);
                     if (!scan_res.found) begin
                        if (table_full) begin
                           rsp_evict_in = 1'b1;
                        end else begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  OP_CONNECT: begin
                     if (scan_res.level == LEVEL_UNKNOWN) begin
                        // unknown or unmatched station arms the prompt
                        prompt_in = 1'b1;
                     end else begin
                        // known station: refresh last-use time only
                        wr_en        = 1'b1;
                        wr_addr      = scan_res.match_idx[IDX_W-1:0];
                        wr_row.level = scan_res.level;
                     end
                  end
                  OP_CONSUME: begin
                     prompt_in = 1'b0;
                  end
                  default: begin
                     // lookup leaves the table alone
                  end
               endcase
               rsp_valid_in  = 1'b1;
               rsp_level_in  = scan_res.level;
               rsp_hit_in    = scan_res.found;
               rsp_allow_in  = ap_ff || (scan_res.level >= required_ff);
               rsp_prompt_in = prompt_in;
               rsp_slot_in   = slot_wide[SLOT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         count_ff     <= '0;
         prompt_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         count_ff     <= count_in;
         prompt_ff    <= prompt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff    <= rd_addr_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_allow_ff  <= rsp_allow_in;
      rsp_prompt_ff <= rsp_prompt_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_evict_ff  <= rsp_evict_in;
      if (accept) begin
         op_ff        <= req_operation;
         key_ff       <= {req_station_addr, req_name_word0, req_name_word1,
                          req_name_word2, req_name_word3};
         new_level_ff <= req_new_level;
         now_ff       <= req_now_ms;
         required_ff  <= req_required_level;
         ap_ff        <= req_ap_mode;
      end
   end

   // one row per entry: key, level and last-use time
   ktt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // shared compare and oldest-time unit
   ktt_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .key   (key_ff),
      .row   (rd_row),
      .res   (scan_res)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found_level    = rsp_level_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_allowed        = rsp_allow_ff;
   assign rsp_prompt_pending = rsp_prompt_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_evicted        = rsp_evict_ff;

endmodule

`default_nettype wire

@@ src/ktt_checker.sv @@
// ============================================================================
// ktt_checker
// port-level checks for the keyed trust table
// ============================================================================
`default_nettype none

module ktt_checker
   import ktt_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [LEVEL_W-1:0] rsp_found_level,
   input wire logic               rsp_hit,
   input wire logic [SLOT_W-1:0]  rsp_slot,
   input wire logic               rsp_evicted
);

   // not ready again right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ktt: ready right after accepting a request");

   // a miss reports level unknown
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_found_level == LEVEL_UNKNOWN)
      else $error("ktt: miss with nonzero level");

   // eviction only happens for a store that missed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit)
      else $error("ktt: eviction reported on a hit");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_hit))
      else $error("ktt: stalled response changed");

endmodule

bind keyed_trust_table_lru_unit ktt_checker u_ktt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_found_level (rsp_found_level),
   .rsp_hit         (rsp_hit),
   .rsp_slot        (rsp_slot),
   .rsp_evicted     (rsp_evicted)
);

`default_nettype wire
